// File: hw/rtl/tpmmq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpmmq_pkg
// Shared types and constants for the tree path min/max query block.
// ----------------------------------------------------------------------------
package tpmmq_pkg;
    localparam int NODE_BITS   = 16;
    localparam int LEVELS      = 16;
    localparam int LVL_BITS    = 4;
    localparam int WEIGHT_BITS = 20;
    localparam int DEPTH_BITS  = 16;
    localparam int SLOT_BITS   = NODE_BITS + LVL_BITS;

    localparam logic REQ_ATTACH = 1'b0;
    localparam logic REQ_QUERY  = 1'b1;

    typedef struct packed {
        logic                   req_type;
        logic [NODE_BITS-1:0]   node;
        logic [NODE_BITS-1:0]   other_node;
        logic [WEIGHT_BITS-1:0] weight;
        logic                   is_root;
    } t_in_word;

    typedef struct packed {
        logic [WEIGHT_BITS-1:0] min_weight;
        logic [WEIGHT_BITS-1:0] max_weight;
        logic                   path_empty;
    } t_out_word;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_A_DRD, ST_A_DWAIT, ST_A_BASE, ST_A_RD1, ST_A_WAIT1, ST_A_RD2, ST_A_WAIT2,
        ST_A_WR,
        ST_Q_DRD, ST_Q_DWAIT, ST_Q_LRD, ST_Q_LWAIT, ST_Q_LDRD, ST_Q_LDWAIT, ST_Q_LSTEP,
        ST_Q_JRD, ST_Q_JWAIT, ST_Q_JSTEP, ST_Q_FRD, ST_Q_FWAIT, ST_Q_FSTEP,
        ST_OUT
    } t_state;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_DEPTH_RD,
        CMD_DEPTH_CAP,
        CMD_A_BASE,
        CMD_A_RD_U,
        CMD_A_CAP_U,
        CMD_A_RD_AN,
        CMD_A_WRITE,
        CMD_RD_V,
        CMD_RD_U,
        CMD_DEPTH_AN_RD,
        CMD_L_STEP,
        CMD_J_STEP,
        CMD_F_STEP,
        CMD_EMIT
    } t_cmd_op;

    typedef struct packed {
        t_cmd_op             op;
        logic [LVL_BITS-1:0] level;
    } t_cmd;

    typedef struct packed {
        logic is_query;
        logic bad;
        logic same;
        logic v_eq_u;
        logic out_full;
    } t_status;
endpackage

// File: hw/rtl/tpmmq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpmmq_ctrl
// Sequencer for attach builds and two-pass query climbs.
// ----------------------------------------------------------------------------
module tpmmq_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  tpmmq_pkg::t_status i_status,
    output tpmmq_pkg::t_cmd    o_cmd
);
    tpmmq_pkg::t_state r_state, n_state;
    logic [tpmmq_pkg::LVL_BITS-1:0] r_lvl, n_lvl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tpmmq_pkg::ST_IDLE;
            r_lvl   <= '0;
        end else begin
            r_state <= n_state;
            r_lvl   <= n_lvl;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_lvl    = r_lvl;
        o_stall  = 1'b1;
        o_cmd.op = tpmmq_pkg::CMD_NONE;
        o_cmd.level = r_lvl;
        case (r_state)
            tpmmq_pkg::ST_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    o_cmd.op = tpmmq_pkg::CMD_LOAD;
                    n_state  = tpmmq_pkg::ST_A_DRD;
                end
            end
            tpmmq_pkg::ST_A_DRD: begin
                if (i_status.is_query) begin
                    n_state = tpmmq_pkg::ST_Q_DRD;
                end else if (i_status.bad) begin
                    n_state = tpmmq_pkg::ST_IDLE;
                end else begin
                    o_cmd.op = tpmmq_pkg::CMD_DEPTH_RD;
                    n_state  = tpmmq_pkg::ST_A_DWAIT;
                end
            end
            tpmmq_pkg::ST_A_DWAIT: begin
                n_state = tpmmq_pkg::ST_A_BASE;
            end
            tpmmq_pkg::ST_A_BASE: begin
                o_cmd.op = tpmmq_pkg::CMD_A_BASE;
                n_lvl    = 4'd1;
                n_state  = (tpmmq_pkg::LEVELS > 1) ? tpmmq_pkg::ST_A_RD1 : tpmmq_pkg::ST_IDLE;
            end
            tpmmq_pkg::ST_A_RD1: begin
                o_cmd.op = tpmmq_pkg::CMD_A_RD_U;
                n_state  = tpmmq_pkg::ST_A_WAIT1;
            end
            tpmmq_pkg::ST_A_WAIT1: begin
                o_cmd.op = tpmmq_pkg::CMD_A_CAP_U;
                n_state  = tpmmq_pkg::ST_A_RD2;
            end
            tpmmq_pkg::ST_A_RD2: begin
                o_cmd.op = tpmmq_pkg::CMD_A_RD_AN;
                n_state  = tpmmq_pkg::ST_A_WAIT2;
            end
            tpmmq_pkg::ST_A_WAIT2: begin
                o_cmd.op = tpmmq_pkg::CMD_A_RD_AN;
                n_state  = tpmmq_pkg::ST_A_WR;
            end
            tpmmq_pkg::ST_A_WR: begin
                o_cmd.op = tpmmq_pkg::CMD_A_WRITE;
                if (r_lvl == 4'(tpmmq_pkg::LEVELS - 1)) begin
                    n_state = tpmmq_pkg::ST_IDLE;
                end else begin
                    n_lvl   = r_lvl + 4'd1;
                    n_state = tpmmq_pkg::ST_A_RD1;
                end
            end
            tpmmq_pkg::ST_Q_DRD: begin
                if (i_status.bad || i_status.same) begin
                    n_state = tpmmq_pkg::ST_OUT;
                end else begin
                    o_cmd.op = tpmmq_pkg::CMD_DEPTH_RD;
                    n_state  = tpmmq_pkg::ST_Q_DWAIT;
                end
            end
            tpmmq_pkg::ST_Q_DWAIT: begin
                o_cmd.op = tpmmq_pkg::CMD_DEPTH_CAP;
                n_lvl    = 4'(tpmmq_pkg::LEVELS - 1);
                n_state  = tpmmq_pkg::ST_Q_LRD;
            end
            tpmmq_pkg::ST_Q_LRD: begin
                o_cmd.op = tpmmq_pkg::CMD_RD_V;
                n_state  = tpmmq_pkg::ST_Q_LWAIT;
            end
            tpmmq_pkg::ST_Q_LWAIT: begin
                n_state = tpmmq_pkg::ST_Q_LDRD;
            end
            tpmmq_pkg::ST_Q_LDRD: begin
                o_cmd.op = tpmmq_pkg::CMD_DEPTH_AN_RD;
                n_state  = tpmmq_pkg::ST_Q_LDWAIT;
            end
            tpmmq_pkg::ST_Q_LDWAIT: begin
                n_state = tpmmq_pkg::ST_Q_LSTEP;
            end
            tpmmq_pkg::ST_Q_LSTEP: begin
                o_cmd.op = tpmmq_pkg::CMD_L_STEP;
                if (r_lvl == '0) begin
                    n_lvl   = 4'(tpmmq_pkg::LEVELS - 1);
                    n_state = tpmmq_pkg::ST_Q_JRD;
                end else begin
                    n_lvl   = r_lvl - 4'd1;
                    n_state = tpmmq_pkg::ST_Q_LRD;
                end
            end
            tpmmq_pkg::ST_Q_JRD: begin
                if (i_status.v_eq_u) begin
                    n_state = tpmmq_pkg::ST_OUT;
                end else begin
                    o_cmd.op = tpmmq_pkg::CMD_RD_U;
                    n_state  = tpmmq_pkg::ST_Q_JWAIT;
                end
            end
            tpmmq_pkg::ST_Q_JWAIT: begin
                n_state = tpmmq_pkg::ST_Q_JSTEP;
            end
            tpmmq_pkg::ST_Q_JSTEP: begin
                o_cmd.op = tpmmq_pkg::CMD_J_STEP;
                if (r_lvl == '0) begin
                    n_state = tpmmq_pkg::ST_Q_FRD;
                end else begin
                    n_lvl   = r_lvl - 4'd1;
                    n_state = tpmmq_pkg::ST_Q_JRD;
                end
            end
            tpmmq_pkg::ST_Q_FRD: begin
                o_cmd.op = tpmmq_pkg::CMD_RD_U;
                n_state  = tpmmq_pkg::ST_Q_FWAIT;
            end
            tpmmq_pkg::ST_Q_FWAIT: begin
                n_state = tpmmq_pkg::ST_Q_FSTEP;
            end
            tpmmq_pkg::ST_Q_FSTEP: begin
                o_cmd.op = tpmmq_pkg::CMD_F_STEP;
                n_state  = tpmmq_pkg::ST_OUT;
            end
            tpmmq_pkg::ST_OUT: begin
                if (!i_status.out_full) begin
                    o_cmd.op = tpmmq_pkg::CMD_EMIT;
                    n_state  = tpmmq_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = tpmmq_pkg::ST_IDLE;
            end
        endcase
    end
endmodule

// File: hw/rtl/tpmmq_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpmmq_dp
// Lifting tables, node registers, min/max accumulator and output register.
// ----------------------------------------------------------------------------
module tpmmq_dp (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  tpmmq_pkg::t_in_word  i_in,
    input  tpmmq_pkg::t_cmd      i_cmd,
    output tpmmq_pkg::t_status   o_status,
    output logic                 o_valid,
    input  logic                 i_stall,
    output tpmmq_pkg::t_out_word o_out
);
    localparam int NB = tpmmq_pkg::NODE_BITS;
    localparam int WB = tpmmq_pkg::WEIGHT_BITS;
    localparam int DB = tpmmq_pkg::DEPTH_BITS;
    localparam int SB = tpmmq_pkg::SLOT_BITS;
    localparam int TW = 1 + NB + WB + WB;

    // table entry: valid, ancestor, min, max
    logic [TW-1:0] r_tbl_a [2**SB];
    logic [TW-1:0] r_tbl_b [2**SB];
    logic [DB-1:0] r_dep_a [2**NB];
    logic [DB-1:0] r_dep_b [2**NB];

    logic [SB-1:0] tbl_ra, tbl_rb, tbl_wa;
    logic [TW-1:0] tbl_wd, r_tqa, r_tqb;
    logic          tbl_we;
    logic [NB-1:0] dep_ra, dep_rb, dep_wa;
    logic [DB-1:0] dep_wd, r_dqa, r_dqb;
    logic          dep_we;

    always_ff @(posedge i_clk) begin
        if (tbl_we) begin
            r_tbl_a[tbl_wa] <= tbl_wd;
            r_tbl_b[tbl_wa] <= tbl_wd;
        end
        r_tqa <= r_tbl_a[tbl_ra];
        r_tqb <= r_tbl_b[tbl_rb];
    end

    always_ff @(posedge i_clk) begin
        if (dep_we) begin
            r_dep_a[dep_wa] <= dep_wd;
            r_dep_b[dep_wa] <= dep_wd;
        end
        r_dqa <= r_dep_a[dep_ra];
        r_dqb <= r_dep_b[dep_rb];
    end

    logic          r_isq, r_root;
    logic [NB-1:0] r_u, r_v, r_p;
    logic [WB-1:0] r_w, r_lo, r_hi, r_l1, r_h1;
    logic [NB-1:0] r_an;
    logic          r_anv;
    logic [DB-1:0] r_du, r_ddep;
    logic          r_any;
    logic          r_ovalid;
    tpmmq_pkg::t_out_word r_out;

    logic          qv_v, qu_v;
    logic [NB-1:0] qv_n, qu_n;
    logic [WB-1:0] qv_lo, qv_hi, qu_lo, qu_hi;
    logic [WB-1:0] acc_lo, acc_hi, m_lo, m_hi;
    logic          acc_any;

    assign qv_v  = r_tqa[TW-1];
    assign qv_n  = r_tqa[TW-2 -: NB];
    assign qv_lo = r_tqa[2*WB-1 -: WB];
    assign qv_hi = r_tqa[WB-1:0];
    assign qu_v  = r_tqb[TW-1];
    assign qu_n  = r_tqb[TW-2 -: NB];
    assign qu_lo = r_tqb[2*WB-1 -: WB];
    assign qu_hi = r_tqb[WB-1:0];

    assign o_status.is_query = r_isq;
    assign o_status.bad      = 1'b0;
    assign o_status.same     = r_isq && (r_u == r_v);
    assign o_status.v_eq_u   = (r_u == r_v);
    assign o_status.out_full = r_ovalid && i_stall;
    assign o_valid = r_ovalid;
    assign o_out   = r_out;

    always_comb begin
        tbl_ra = {r_v, i_cmd.level};
        tbl_rb = {r_u, i_cmd.level};
        dep_ra = r_u;
        dep_rb = r_v;
        tbl_we = 1'b0;
        tbl_wa = {r_u, i_cmd.level};
        tbl_wd = '0;
        dep_we = 1'b0;
        dep_wa = r_u;
        dep_wd = r_root ? '0 : r_dqb + 16'd1;
        m_lo   = '0;
        m_hi   = '0;
        case (i_cmd.op)
            tpmmq_pkg::CMD_DEPTH_RD: begin
                dep_rb = r_isq ? r_v : r_p;
            end
            tpmmq_pkg::CMD_A_BASE: begin
                dep_we = 1'b1;
                tbl_we = 1'b1;
                tbl_wa = {r_u, 4'd0};
                tbl_wd = r_root ? '0 : {1'b1, r_p, r_w, r_w};
            end
            tpmmq_pkg::CMD_A_RD_U: begin
                tbl_ra = {r_u, i_cmd.level - 4'd1};
            end
            tpmmq_pkg::CMD_A_RD_AN: begin
                tbl_ra = {r_an, i_cmd.level - 4'd1};
            end
            tpmmq_pkg::CMD_A_WRITE: begin
                tbl_we = 1'b1;
                m_lo   = (r_l1 < qv_lo) ? r_l1 : qv_lo;
                m_hi   = (r_h1 > qv_hi) ? r_h1 : qv_hi;
                tbl_wd = (r_anv && qv_v) ? {1'b1, qv_n, m_lo, m_hi} : '0;
            end
            tpmmq_pkg::CMD_DEPTH_AN_RD: begin
                dep_rb = qv_n;
            end
            tpmmq_pkg::CMD_F_STEP: begin
                tbl_ra = {r_v, 4'd0};
            end
            default: begin
            end
        endcase
    end

    // accumulator with one or two taken entries
    logic          take1, take2;
    logic [WB-1:0] t1_lo, t1_hi, t2_lo, t2_hi;
    always_comb begin
        take1 = 1'b0;
        take2 = 1'b0;
        t1_lo = qv_lo;
        t1_hi = qv_hi;
        t2_lo = qu_lo;
        t2_hi = qu_hi;
        case (i_cmd.op)
            tpmmq_pkg::CMD_L_STEP: take1 = qv_v && (r_ddep >= r_du);
            tpmmq_pkg::CMD_J_STEP: begin
                take1 = qv_v && qu_v && (qv_n != qu_n);
                take2 = take1;
            end
            tpmmq_pkg::CMD_F_STEP: begin
                take1 = qv_v;
                take2 = qu_v;
            end
            default: begin
            end
        endcase
        acc_any = r_any;
        acc_lo  = r_lo;
        acc_hi  = r_hi;
        if (i_cmd.op == tpmmq_pkg::CMD_LOAD) begin
            acc_any = 1'b0;
            acc_lo  = '0;
            acc_hi  = '0;
        end
        if (take1) begin
            acc_lo  = (!acc_any || t1_lo < acc_lo) ? t1_lo : acc_lo;
            acc_hi  = (!acc_any || t1_hi > acc_hi) ? t1_hi : acc_hi;
            acc_any = 1'b1;
        end
        if (take2) begin
            acc_lo  = (!acc_any || t2_lo < acc_lo) ? t2_lo : acc_lo;
            acc_hi  = (!acc_any || t2_hi > acc_hi) ? t2_hi : acc_hi;
            acc_any = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else begin
            if (i_cmd.op == tpmmq_pkg::CMD_EMIT) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && !i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo  <= acc_lo;
        r_hi  <= acc_hi;
        r_any <= acc_any;
        case (i_cmd.op)
            tpmmq_pkg::CMD_LOAD: begin
                r_isq  <= (i_in.req_type == tpmmq_pkg::REQ_QUERY);
                r_root <= i_in.is_root;
                r_u    <= i_in.node;
                r_v    <= i_in.other_node;
                r_p    <= i_in.other_node;
                r_w    <= i_in.weight;
            end
            tpmmq_pkg::CMD_DEPTH_CAP: begin
                if (r_dqa > r_dqb) begin
                    r_u  <= r_v;
                    r_v  <= r_u;
                    r_du <= r_dqb;
                end else begin
                    r_du <= r_dqa;
                end
            end
            tpmmq_pkg::CMD_A_CAP_U: begin
                r_anv <= qv_v;
                r_an  <= qv_n;
                r_l1  <= qv_lo;
                r_h1  <= qv_hi;
            end
            tpmmq_pkg::CMD_L_STEP: begin
                if (take1) begin
                    r_v <= qv_n;
                end
            end
            tpmmq_pkg::CMD_J_STEP: begin
                if (take1) begin
                    r_v <= qv_n;
                    r_u <= qu_n;
                end
            end
            tpmmq_pkg::CMD_EMIT: begin
                r_out.path_empty <= r_isq && (r_u == r_v) && !r_any;
                r_out.min_weight <= r_any ? r_lo : '0;
                r_out.max_weight <= r_any ? r_hi : '0;
            end
            default: begin
            end
        endcase
        r_ddep <= r_dqb;
    end
endmodule

// File: hw/rtl/tree_path_min_max_query.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tree_path_min_max_query
// Binary-lifting tree store answering path min/max edge weight queries.
//
//   channel | direction | handshake          | word
//   in      | input     | i_valid / o_stall  | tpmmq_pkg::t_in_word
//   out     | output    | o_valid / i_stall  | tpmmq_pkg::t_out_word
//
// An attach makes two dependent table reads per level, levels 1 to LEVELS-1.
// A query makes one lift pass and one joint pass over the duplicated lifting
// table; a same-node query goes straight to the output.
// Reset clears control only; tables hold garbage until written.
// A stalled result holds in the output register; a following query holds before emit.
// ----------------------------------------------------------------------------
module tree_path_min_max_query (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  tpmmq_pkg::t_in_word  i_in,
    output logic                 o_valid,
    input  logic                 i_stall,
    output tpmmq_pkg::t_out_word o_out
);
    tpmmq_pkg::t_cmd    cmd;
    tpmmq_pkg::t_status status;

    tpmmq_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_status (status),
        .o_cmd    (cmd)
    );

    tpmmq_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_cmd    (cmd),
        .o_status (status),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_out    (o_out)
    );
endmodule

// File: test/tb_tree_path_min_max_query.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tree_path_min_max_query
// Self-checking bench for the binary-lifting path min/max block.
// Builds forests through attach words and checks every query result
// against a behavioral copy of the lifting tables. Input words idle and
// output results stall at random. Directed trees cover the weight extremes, the
// same-node query, disconnected roots and re-attach. Random forests then
// reach deep chains, with roughly 750 words in total.
// ----------------------------------------------------------------------------
module tb_tree_path_min_max_query;
    localparam int SETTLE_CYCLES = 200;
    localparam int NB = tpmmq_pkg::NODE_BITS;
    localparam int WB = tpmmq_pkg::WEIGHT_BITS;
    localparam int DB = tpmmq_pkg::DEPTH_BITS;
    localparam int LV = tpmmq_pkg::LEVELS;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 o_stall;
    tpmmq_pkg::t_in_word  i_in = '0;
    logic                 o_valid;
    logic                 i_stall = 1'b0;
    tpmmq_pkg::t_out_word o_out;

    tree_path_min_max_query dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_in    (i_in),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_out   (o_out)
    );

    always #5 i_clk = ~i_clk;

    logic [16:0]          anc_tab [int];
    logic [WB-1:0]        lo_tab  [int];
    logic [WB-1:0]        hi_tab  [int];
    logic [DB-1:0]        dep_tab [int];
    bit                   is_live [int];
    logic [NB-1:0]        live_q  [$];
    tpmmq_pkg::t_out_word pending_q [$];

    int errors = 0;
    int n_attach = 0;
    int n_query = 0;
    int n_checked = 0;
    int stall_left = 0;
    int calm_left = 0;

    function automatic int slot_of(logic [NB-1:0] n, int k);
        return int'(n) * LV + k;
    endfunction

    function automatic void tree_attach(logic [NB-1:0] u, logic [NB-1:0] p,
                                        logic [WB-1:0] w, logic root);
        logic [16:0] a;
        logic [16:0] nxt;
        logic [NB-1:0] an;
        logic [WB-1:0] lo;
        logic [WB-1:0] hi;
        if (root) begin
            dep_tab[u] = '0;
            anc_tab[slot_of(u, 0)] = '0;
            lo_tab[slot_of(u, 0)] = '0;
            hi_tab[slot_of(u, 0)] = '0;
        end else begin
            dep_tab[u] = dep_tab[p] + 16'd1;
            anc_tab[slot_of(u, 0)] = {1'b1, p};
            lo_tab[slot_of(u, 0)] = w;
            hi_tab[slot_of(u, 0)] = w;
        end
        for (int k = 1; k < LV; k++) begin
            a = anc_tab[slot_of(u, k - 1)];
            nxt = '0;
            lo = '0;
            hi = '0;
            if (a[16]) begin
                an = a[15:0];
                nxt = anc_tab[slot_of(an, k - 1)];
                if (nxt[16]) begin
                    lo = lo_tab[slot_of(u, k - 1)];
                    if (lo_tab[slot_of(an, k - 1)] < lo) lo = lo_tab[slot_of(an, k - 1)];
                    hi = hi_tab[slot_of(u, k - 1)];
                    if (hi_tab[slot_of(an, k - 1)] > hi) hi = hi_tab[slot_of(an, k - 1)];
                end else begin
                    nxt = '0;
                end
            end
            anc_tab[slot_of(u, k)] = nxt;
            lo_tab[slot_of(u, k)] = lo;
            hi_tab[slot_of(u, k)] = hi;
        end
    endfunction

    function automatic tpmmq_pkg::t_out_word path_extremes(logic [NB-1:0] a_in,
                                                           logic [NB-1:0] b_in);
        tpmmq_pkg::t_out_word r;
        logic [NB-1:0] u;
        logic [NB-1:0] v;
        logic [NB-1:0] t;
        logic [16:0] av;
        logic [16:0] au;
        bit any;
        logic [WB-1:0] lo;
        logic [WB-1:0] hi;
        r = '0;
        if (a_in == b_in) begin
            r.path_empty = 1'b1;
            return r;
        end
        any = 0;
        lo = '0;
        hi = '0;
        u = a_in;
        v = b_in;
        if (dep_tab[u] > dep_tab[v]) begin
            t = u; u = v; v = t;
        end
        for (int k = LV - 1; k >= 0; k--) begin
            av = anc_tab[slot_of(v, k)];
            if (av[16] && dep_tab[av[15:0]] >= dep_tab[u]) begin
                if (!any || lo_tab[slot_of(v, k)] < lo) lo = lo_tab[slot_of(v, k)];
                if (!any || hi_tab[slot_of(v, k)] > hi) hi = hi_tab[slot_of(v, k)];
                any = 1;
                v = av[15:0];
            end
        end
        if (v != u) begin
            for (int k = LV - 1; k >= 0; k--) begin
                av = anc_tab[slot_of(v, k)];
                au = anc_tab[slot_of(u, k)];
                if (av[16] && au[16] && av != au) begin
                    if (!any || lo_tab[slot_of(v, k)] < lo) lo = lo_tab[slot_of(v, k)];
                    if (!any || hi_tab[slot_of(v, k)] > hi) hi = hi_tab[slot_of(v, k)];
                    any = 1;
                    if (lo_tab[slot_of(u, k)] < lo) lo = lo_tab[slot_of(u, k)];
                    if (hi_tab[slot_of(u, k)] > hi) hi = hi_tab[slot_of(u, k)];
                    v = av[15:0];
                    u = au[15:0];
                end
            end
            if (anc_tab[slot_of(v, 0)][16]) begin
                if (!any || lo_tab[slot_of(v, 0)] < lo) lo = lo_tab[slot_of(v, 0)];
                if (!any || hi_tab[slot_of(v, 0)] > hi) hi = hi_tab[slot_of(v, 0)];
                any = 1;
            end
            if (anc_tab[slot_of(u, 0)][16]) begin
                if (!any || lo_tab[slot_of(u, 0)] < lo) lo = lo_tab[slot_of(u, 0)];
                if (!any || hi_tab[slot_of(u, 0)] > hi) hi = hi_tab[slot_of(u, 0)];
                any = 1;
            end
        end
        if (any) begin
            r.min_weight = lo;
            r.max_weight = hi;
        end
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_word(tpmmq_pkg::t_in_word w);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_in <= w;
        @(posedge i_clk iff !o_stall);
        if (w.req_type == tpmmq_pkg::REQ_ATTACH) begin
            tree_attach(w.node, w.other_node, w.weight, w.is_root);
            n_attach++;
            if (!is_live.exists(int'(w.node))) begin
                is_live[int'(w.node)] = 1;
                live_q.insert(live_q.size(), w.node);
            end
        end else begin
            pending_q.insert(pending_q.size(), path_extremes(w.node, w.other_node));
            n_query++;
        end
    endtask

    task automatic attach_word(logic [NB-1:0] u, logic [NB-1:0] p,
                               logic [WB-1:0] w, logic root);
        tpmmq_pkg::t_in_word x;
        x.req_type = tpmmq_pkg::REQ_ATTACH;
        x.node = u;
        x.other_node = p;
        x.weight = w;
        x.is_root = root;
        send_word(x);
    endtask

    task automatic query_word(logic [NB-1:0] a, logic [NB-1:0] b);
        tpmmq_pkg::t_in_word x;
        x.req_type = tpmmq_pkg::REQ_QUERY;
        x.node = a;
        x.other_node = b;
        x.weight = WB'($urandom());
        x.is_root = 1'($urandom());
        send_word(x);
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // directed: weight extremes, same node, disconnected roots, re-attach
    task automatic test_directed();
        attach_word(16'h0000, 16'hFFFF, 20'hFFFFF, 1'b1);
        attach_word(16'hFFFF, 16'h1234, 20'h00000, 1'b1);
        attach_word(16'h0001, 16'h0000, 20'h00000, 1'b0);
        attach_word(16'h0002, 16'h0001, 20'hFFFFF, 1'b0);
        attach_word(16'h0003, 16'h0002, 20'h5A5A5, 1'b0);
        attach_word(16'h0004, 16'h0003, 20'hA5A5A, 1'b0);
        attach_word(16'h0005, 16'h0004, 20'h00010, 1'b0);
        attach_word(16'h0006, 16'h0005, 20'h80000, 1'b0);
        attach_word(16'h0007, 16'h0006, 20'h00001, 1'b0);
        attach_word(16'h0008, 16'h0002, 20'h7FFFF, 1'b0);
        attach_word(16'h8000, 16'hFFFF, 20'hFFFFF, 1'b0);
        query_word(16'h0005, 16'h0005);
        query_word(16'h0007, 16'h0000);
        query_word(16'h0000, 16'h0007);
        query_word(16'h0007, 16'h0008);
        query_word(16'h0002, 16'h0001);
        query_word(16'h0007, 16'h8000);
        query_word(16'h0000, 16'hFFFF);
        query_word(16'h8000, 16'hFFFF);
        attach_word(16'h0004, 16'h0000, 20'h12345, 1'b1);
        query_word(16'h0007, 16'h0003);
        query_word(16'h0007, 16'h0001);
        attach_word(16'h0004, 16'h8000, 20'h00002, 1'b0);
        query_word(16'h0004, 16'hFFFF);
        query_word(16'h0007, 16'h0008);
        drain_results();
    endtask

    task automatic test_random_forest(int count);
        logic [NB-1:0] u;
        logic [NB-1:0] p;
        int r;
        int span;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(0, 99);
            if (r < 40 || live_q.size() < 4) begin
                do u = NB'($urandom()); while (is_live.exists(int'(u)));
                if (r < 4) begin
                    attach_word(u, NB'($urandom()), WB'($urandom()), 1'b1);
                end else begin
                    // favor recent nodes so chains grow deep
                    span = (live_q.size() < 8) ? live_q.size() : 8;
                    if ($urandom_range(0, 3) != 0)
                        p = live_q[live_q.size() - 1 - $urandom_range(0, span - 1)];
                    else
                        p = live_q[$urandom_range(0, live_q.size() - 1)];
                    attach_word(u, p, WB'($urandom()), 1'b0);
                end
            end else if (r < 45) begin
                u = live_q[$urandom_range(0, live_q.size() - 1)];
                p = live_q[$urandom_range(0, live_q.size() - 1)];
                attach_word(u, p, WB'($urandom()), 1'($urandom_range(0, 4) == 0));
            end else if (r < 50) begin
                u = live_q[$urandom_range(0, live_q.size() - 1)];
                query_word(u, u);
            end else begin
                query_word(live_q[$urandom_range(0, live_q.size() - 1)],
                           live_q[$urandom_range(0, live_q.size() - 1)]);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (calm_left > 0) begin
            calm_left <= calm_left - 1;
            i_stall <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_stall <= 1'b1;
        end else if ($urandom_range(0, 199) == 0) begin
            calm_left <= $urandom_range(50, 300);
            i_stall <= 1'b0;
        end else if ($urandom_range(0, 49) == 0) begin
            stall_left <= $urandom_range(10, 40);
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(0, 99) < 30);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_q.size() == 0) begin
                $error("result with nothing expected: min=%0h max=%0h empty=%0b",
                       o_out.min_weight, o_out.max_weight, o_out.path_empty);
                errors++;
            end else begin
                if (o_out.min_weight !== pending_q[0].min_weight) begin
                    $error("min_weight expected %0h actual %0h",
                           pending_q[0].min_weight, o_out.min_weight);
                    errors++;
                end
                if (o_out.max_weight !== pending_q[0].max_weight) begin
                    $error("max_weight expected %0h actual %0h",
                           pending_q[0].max_weight, o_out.max_weight);
                    errors++;
                end
                if (o_out.path_empty !== pending_q[0].path_empty) begin
                    $error("path_empty expected %0b actual %0b",
                           pending_q[0].path_empty, o_out.path_empty);
                    errors++;
                end
                void'(pending_q.pop_front());
                n_checked++;
            end
        end
    end

    initial begin
        #20ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random_forest(360);
        drain_results();
        test_random_forest(360);
        drain_results();
        if (pending_q.size() != 0) begin
            $error("%0d results never arrived", pending_q.size());
            errors++;
        end
        $display("Covered %0d attach and %0d query words over %0d nodes; %0d results checked.",
                 n_attach, n_query, live_q.size(), n_checked);
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule

// File: sim.f
hw/rtl/tpmmq_pkg.sv
hw/rtl/tpmmq_ctrl.sv
hw/rtl/tpmmq_dp.sv
hw/rtl/tree_path_min_max_query.sv
test/tb_tree_path_min_max_query.sv
